// ===== sv/obk_pkg.sv =====
package obk_pkg;

  localparam int MAX_ORDERS  = 256;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(MAX_ORDERS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SORT_DEPTH  = MAX_RESULTS + 1;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_MATCH  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_MATCH  = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] order_id;
    logic [31:0] price;
    logic [31:0] quantity;
  } req_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] match_order_id;
    logic [31:0] match_price;
    logic [31:0] match_quantity;
    logic        last;
  } rsp_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] order_id;
    logic [31:0] price;
    logic [31:0] quantity;
  } entry_t;

  typedef enum logic [2:0] {
    BOOK_HOLD,
    BOOK_COMPARE,
    BOOK_ROTATE,
    BOOK_REMOVE,
    BOOK_UPDATE,
    BOOK_ADD
  } book_op_t;

  typedef struct packed {
    book_op_t         op;
    logic [IDX_W-1:0] sel;
    logic [31:0]      key_id;
    logic [31:0]      new_price;
    logic [31:0]      new_qty;
  } book_cmd_t;

  typedef enum logic [1:0] {
    SORT_HOLD,
    SORT_CLEAR,
    SORT_INSERT,
    SORT_POP
  } sort_op_t;

  typedef struct packed {
    sort_op_t op;
    logic     buy_side;
    entry_t   cand;
  } sort_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_LOCATE,
    S_APPLY,
    S_SCAN,
    S_EMIT
  } state_t;

endpackage

// ===== sv/order_book_side_tracker.sv =====
// Add, remove, update: the book cells compare ids (S_SEARCH), the hit is captured
//   (S_LOCATE), and the result is loaded in S_APPLY once the output is free; the next item is taken back in S_IDLE.
// Match: one full turn rotates the book ring through the sorter chain (S_SCAN), then
//   S_EMIT gives one result per cycle (up to MAX_RESULTS) while the output is taken.
//   One item at a time; rotation sets match cost.
// Reset (rst, synchronous, active high): book empty, buy_side = 1, no result.
module order_book_side_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               req_valid,
  output logic               req_ready,
  input  obk_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output obk_pkg::rsp_item_t rsp
);
  import obk_pkg::*;

  // control state
  state_t           state, state_next;
  logic             buy_side;
  req_item_t        item;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] scan_cnt;
  logic [RES_W-1:0] n_emit;
  logic [31:0]      rem;

  // located order, captured in the cycle after the id compare
  logic             hit_any;
  logic [IDX_W-1:0] hit_idx;
  logic [31:0]      hit_price;
  logic [31:0]      hit_qty;
  logic             loc_any;
  logic [IDX_W-1:0] loc_idx;
  logic [31:0]      loc_price;
  logic [31:0]      loc_qty;

  // book ring: cell 0 holds the oldest order, cells packed in arrival order
  entry_t                book_q  [MAX_ORDERS];
  entry_t                book_up [MAX_ORDERS];
  logic [MAX_ORDERS-1:0] book_hit;
  book_cmd_t             bcmd;

  // sorter chain: head holds the best eligible order seen so far
  entry_t    srt_q      [SORT_DEPTH];
  logic      srt_better [SORT_DEPTH];
  sort_cmd_t scmd;
  entry_t    cand;

  // match step values
  logic [31:0] take_qty;
  logic [31:0] rem_after;
  logic        at_limit;
  logic        step_last;
  logic        no_match;

  rsp_item_t rsp_next;
  logic      rsp_load;
  logic      out_free;

  genvar g;

  // ---------------------------------------------------------------- book ring
  generate
    for (g = 0; g < MAX_ORDERS; g++) begin : g_book
      if (g == MAX_ORDERS - 1) begin : g_tail
        // wrap the head around when rotating, feed an empty slot on remove
        assign book_up[g] = (bcmd.op == BOOK_ROTATE) ? book_q[0] : '0;
      end else begin : g_body
        assign book_up[g] = book_q[g+1];
      end
      obk_book_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .idx   (IDX_W'(g)),
        .cmd   (bcmd),
        .upper (book_up[g]),
        .entry (book_q[g]),
        .hit   (book_hit[g])
      );
    end
  endgenerate

  // ids are unique, so at most one hit: OR the one-hot selection together
  always_comb begin
    loc_any   = 1'b0;
    loc_idx   = '0;
    loc_price = '0;
    loc_qty   = '0;
    for (int i = 0; i < MAX_ORDERS; i++) begin
      if (book_hit[i]) begin
        loc_any   = 1'b1;
        loc_idx   = loc_idx | IDX_W'(i);
        loc_price = loc_price | book_q[i].price;
        loc_qty   = loc_qty | book_q[i].quantity;
      end
    end
  end

  // ------------------------------------------------------------- sorter chain
  generate
    for (g = 0; g < SORT_DEPTH; g++) begin : g_sort
      entry_t lo;
      entry_t up;
      logic   lo_better;
      if (g == 0) begin : g_head
        assign lo        = '0;
        assign lo_better = 1'b0;
      end else begin : g_mid
        assign lo        = srt_q[g-1];
        assign lo_better = srt_better[g-1];
      end
      if (g == SORT_DEPTH - 1) begin : g_end
        assign up = '0;
      end else begin : g_up
        assign up = srt_q[g+1];
      end
      obk_sort_cell u_sort (
        .clk          (clk),
        .rst          (rst),
        .cmd          (scmd),
        .lower_better (lo_better),
        .lower        (lo),
        .upper        (up),
        .entry        (srt_q[g]),
        .better       (srt_better[g])
      );
    end
  endgenerate

  // only orders that meet the limit enter the sorter
  always_comb begin
    cand       = book_q[0];
    cand.valid = book_q[0].valid &&
                 (buy_side ? (book_q[0].price >= item.price)
                           : (book_q[0].price <= item.price));
  end

  assign take_qty  = (srt_q[0].quantity < rem) ? srt_q[0].quantity : rem;
  assign rem_after = rem - take_qty;
  assign at_limit  = (n_emit == RES_W'(MAX_RESULTS - 1));
  assign step_last = (rem_after == '0) || !srt_q[1].valid || at_limit;
  assign no_match  = (n_emit == '0) && ((rem == '0) || !srt_q[0].valid);

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  // ------------------------------------------------------------- control FSM
  always_comb begin
    state_next = state;
    count_next = count;
    rsp_load   = 1'b0;
    rsp_next   = '{status: ST_OK, match_order_id: item.order_id,
                   match_price: item.price, match_quantity: item.quantity,
                   last: 1'b1};
    bcmd       = '{op: BOOK_HOLD, sel: '0, key_id: item.order_id,
                   new_price: item.price, new_qty: item.quantity};
    scmd       = '{op: SORT_HOLD, buy_side: buy_side, cand: cand};

    unique case (state)
      S_IDLE: begin
        scmd.op = SORT_CLEAR;
        if (req_valid) state_next = (req.kind == KIND_MATCH) ? S_SCAN : S_SEARCH;
      end
      S_SEARCH: begin
        bcmd.op    = BOOK_COMPARE;
        state_next = S_LOCATE;
      end
      S_LOCATE: state_next = S_APPLY;
      S_APPLY: begin
        if (out_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
          if (item.kind == KIND_ADD) begin
            if (hit_any) begin
              rsp_next.status = ST_DUPLICATE;
            end else if (count == CNT_W'(MAX_ORDERS)) begin
              rsp_next.status = ST_FULL;
            end else begin
              bcmd.op    = BOOK_ADD;
              bcmd.sel   = count[IDX_W-1:0];
              count_next = count + 1'b1;
            end
          end else if (!hit_any) begin
            rsp_next.status         = ST_NOT_FOUND;
            rsp_next.match_price    = '0;
            rsp_next.match_quantity = '0;
          end else if (item.kind == KIND_REMOVE || item.quantity == '0) begin
            // close the gap: every cell from the hit upward takes its neighbor
            bcmd.op                 = BOOK_REMOVE;
            bcmd.sel                = hit_idx;
            count_next              = count - 1'b1;
            rsp_next.match_price    = hit_price;
            rsp_next.match_quantity = (item.kind == KIND_REMOVE) ? hit_qty : '0;
          end else begin
            bcmd.op              = BOOK_UPDATE;
            bcmd.sel             = hit_idx;
            rsp_next.match_price = hit_price;
          end
        end
      end
      S_SCAN: begin
        // one full turn of the ring streams every order past the sorter
        bcmd.op = BOOK_ROTATE;
        scmd.op = SORT_INSERT;
        if (scan_cnt == IDX_W'(MAX_ORDERS - 1)) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          rsp_load = 1'b1;
          if (no_match) begin
            rsp_next.status         = ST_NO_MATCH;
            rsp_next.match_price    = '0;
            rsp_next.match_quantity = '0;
            state_next              = S_IDLE;
          end else begin
            scmd.op                 = SORT_POP;
            rsp_next.match_order_id = srt_q[0].order_id;
            rsp_next.match_price    = srt_q[0].price;
            rsp_next.match_quantity = take_qty;
            rsp_next.last           = step_last;
            // another order would still match past the result limit
            if (at_limit && (rem_after != '0) && srt_q[1].valid)
              rsp_next.status = ST_TRUNCATED;
            if (step_last) state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      buy_side  <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) buy_side <= cfg_wdata;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item     <= req;
      rem      <= req.quantity;
      n_emit   <= '0;
      scan_cnt <= '0;
    end
    if (state == S_SCAN) scan_cnt <= scan_cnt + 1'b1;
    if (state == S_LOCATE) begin
      hit_any   <= loc_any;
      hit_idx   <= loc_idx;
      hit_price <= loc_price;
      hit_qty   <= loc_qty;
    end
    if (state == S_EMIT && rsp_load && !no_match) begin
      rem    <= rem_after;
      n_emit <= n_emit + 1'b1;
    end
    if (rsp_load) rsp <= rsp_next;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ORDERS))
    else $error("order count beyond capacity");

  a_count_apply: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> $past(state) == S_APPLY)
    else $error("order count changed outside apply");

  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_TRUNCATED |-> rsp.last)
    else $error("truncated result not final");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item taken while busy");
`endif

endmodule

// ===== sv/obk_book_cell.sv =====
module obk_book_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [obk_pkg::IDX_W-1:0] idx,
  input  obk_pkg::book_cmd_t       cmd,
  input  obk_pkg::entry_t          upper,
  output obk_pkg::entry_t          entry,
  output logic                     hit
);
  import obk_pkg::*;

  logic        valid;
  logic [31:0] order_id;
  logic [31:0] price;
  logic [31:0] quantity;

  assign entry = '{valid: valid, order_id: order_id, price: price, quantity: quantity};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      unique case (cmd.op)
        BOOK_COMPARE: hit <= valid && (order_id == cmd.key_id);
        BOOK_ROTATE:  valid <= upper.valid;
        BOOK_REMOVE:  if (idx >= cmd.sel) valid <= upper.valid;
        BOOK_ADD:     if (idx == cmd.sel) valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      BOOK_ROTATE: begin
        order_id <= upper.order_id;
        price    <= upper.price;
        quantity <= upper.quantity;
      end
      BOOK_REMOVE: begin
        if (idx >= cmd.sel) begin
          order_id <= upper.order_id;
          price    <= upper.price;
          quantity <= upper.quantity;
        end
      end
      BOOK_UPDATE: if (idx == cmd.sel) quantity <= cmd.new_qty;
      BOOK_ADD: begin
        if (idx == cmd.sel) begin
          order_id <= cmd.key_id;
          price    <= cmd.new_price;
          quantity <= cmd.new_qty;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/obk_sort_cell.sv =====
module obk_sort_cell (
  input  logic               clk,
  input  logic               rst,
  input  obk_pkg::sort_cmd_t cmd,
  input  logic               lower_better,
  input  obk_pkg::entry_t    lower,
  input  obk_pkg::entry_t    upper,
  output obk_pkg::entry_t    entry,
  output logic               better
);
  import obk_pkg::*;

  logic        valid;
  logic [31:0] order_id;
  logic [31:0] price;
  logic [31:0] quantity;
  entry_t      take;
  logic        load;

  assign entry = '{valid: valid, order_id: order_id, price: price, quantity: quantity};

  // strictly better price wins; equal price stays behind, so older first
  assign better = cmd.cand.valid &&
                  (!valid || (cmd.buy_side ? (cmd.cand.price > price)
                                           : (cmd.cand.price < price)));

  always_comb begin
    take = cmd.cand;
    load = 1'b0;
    unique case (cmd.op)
      SORT_INSERT: begin
        load = better;
        take = lower_better ? lower : cmd.cand;
      end
      SORT_POP: begin
        load = 1'b1;
        take = upper;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.op == SORT_CLEAR) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= take.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      order_id <= take.order_id;
      price    <= take.price;
      quantity <= take.quantity;
    end
  end

endmodule

// ===== verif/order_book_side_checker.sv =====
`timescale 1ns / 100ps

module order_book_side_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               req_valid,
  input  logic               req_ready,
  input  obk_pkg::req_item_t req,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  obk_pkg::rsp_item_t rsp,
  output int                 mismatches,
  output int                 pending
);
  import obk_pkg::*;

  logic        side_buy;
  int          book_n;
  logic [31:0] book_id  [MAX_ORDERS];
  logic [31:0] book_px  [MAX_ORDERS];
  logic [31:0] book_qty [MAX_ORDERS];
  rsp_item_t   due_fills [$];

  assign pending = due_fills.size();

  function automatic int locate_id(logic [31:0] id);
    for (int i = 0; i < book_n; i++) begin
      if (book_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic bit ranks_ahead(int a, int b);
    if (book_px[a] != book_px[b])
      return side_buy ? (book_px[a] > book_px[b]) : (book_px[a] < book_px[b]);
    return a < b;
  endfunction

  function automatic void push_fill(status_t st, logic [31:0] id, logic [31:0] px,
                                    logic [31:0] q, logic lst);
    rsp_item_t r;
    r.status = st;
    r.match_order_id = id;
    r.match_price = px;
    r.match_quantity = q;
    r.last = lst;
    due_fills.push_back(r);
  endfunction

  function automatic void apply_item(req_item_t it);
    int s;
    int best;
    int prev;
    int n;
    logic [31:0] rem;
    logic [31:0] m;
    logic [31:0] px;
    logic [31:0] oq;
    rsp_item_t r;
    case (it.kind)
      KIND_ADD: begin
        if (locate_id(it.order_id) >= 0)
          push_fill(ST_DUPLICATE, it.order_id, it.price, it.quantity, 1'b1);
        else if (book_n >= MAX_ORDERS)
          push_fill(ST_FULL, it.order_id, it.price, it.quantity, 1'b1);
        else begin
          book_id[book_n] = it.order_id;
          book_px[book_n] = it.price;
          book_qty[book_n] = it.quantity;
          book_n++;
          push_fill(ST_OK, it.order_id, it.price, it.quantity, 1'b1);
        end
      end
      KIND_REMOVE, KIND_UPDATE: begin
        s = locate_id(it.order_id);
        if (s < 0)
          push_fill(ST_NOT_FOUND, it.order_id, '0, '0, 1'b1);
        else begin
          px = book_px[s];
          oq = book_qty[s];
          if (it.kind == KIND_REMOVE || it.quantity == 0) begin
            for (int i = s; i < book_n - 1; i++) begin
              book_id[i] = book_id[i+1];
              book_px[i] = book_px[i+1];
              book_qty[i] = book_qty[i+1];
            end
            book_n--;
            push_fill(ST_OK, it.order_id, px, (it.kind == KIND_REMOVE) ? oq : '0, 1'b1);
          end else begin
            book_qty[s] = it.quantity;
            push_fill(ST_OK, it.order_id, px, it.quantity, 1'b1);
          end
        end
      end
      default: begin
        // walk the book best first without touching it
        rem = it.quantity;
        n = 0;
        prev = -1;
        while (rem > 0) begin
          best = -1;
          for (int i = 0; i < book_n; i++) begin
            if (prev >= 0 && !ranks_ahead(prev, i)) continue;
            if (best < 0 || ranks_ahead(i, best)) best = i;
          end
          if (best < 0) break;
          if (side_buy ? (book_px[best] < it.price) : (book_px[best] > it.price)) break;
          if (n >= MAX_RESULTS) begin
            r = due_fills.pop_back();
            r.status = ST_TRUNCATED;
            due_fills.push_back(r);
            break;
          end
          m = (book_qty[best] < rem) ? book_qty[best] : rem;
          if (n > 0) begin
            r = due_fills.pop_back();
            r.last = 1'b0;
            due_fills.push_back(r);
          end
          push_fill(ST_OK, book_id[best], book_px[best], m, 1'b1);
          rem -= m;
          prev = best;
          n++;
        end
        if (n == 0) push_fill(ST_NO_MATCH, it.order_id, '0, '0, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      side_buy = 1'b1;
      book_n = 0;
      due_fills.delete();
      mismatches <= 0;
    end else begin
      if (cfg_we) side_buy = cfg_wdata;
      if (rsp_valid && rsp_ready) begin
        if (due_fills.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %p", rsp);
          mismatches <= mismatches + 1;
        end else begin
          want = due_fills.pop_front();
          if (rsp !== want) begin
            if (mismatches < 10) $display("mismatch: expected %p got %p", want, rsp);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (req_valid && req_ready) apply_item(req);
    end
  end

endmodule

// ===== verif/tb_order_book_side_tracker.sv =====
`timescale 1ns / 100ps

module tb_order_book_side_tracker;
  import obk_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;
  int        mismatches;
  int        pending;

  int        send_idle_pct = 0;
  int        take_idle_pct = 0;
  int        hold_off = 0;
  longint    cycles = 0;
  logic [31:0] live_ids [$];

  order_book_side_tracker dut (.*);

  order_book_side_checker chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Guard the run against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb_order_book_side_tracker NOT OK");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here when requested.
  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else if (hold_off > 0) begin
      rsp_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else rsp_ready <= ($urandom_range(99) >= take_idle_pct);
  end

  // Offer one item and hold it until the block takes it; valid stays up for the next.
  task automatic send_item(kind_t k, logic [31:0] id, logic [31:0] px, logic [31:0] q);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req.kind <= k;
    req.order_id <= id;
    req.price <= px;
    req.quantity <= q;
    do @(posedge clk); while (!req_ready);
  endtask

  // Drop valid and wait until every expected result has come.
  task automatic pause_sender();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending > 0);
  endtask

  // Drain all outstanding results, then idle a while.
  task automatic settle();
    pause_sender();
    repeat (MAX_ORDERS + 40) @(posedge clk);
  endtask

  task automatic write_side(logic v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Draw a random item, mostly well formed against ids known to rest.
  task automatic random_item();
    int pick;
    logic [31:0] id;
    logic [31:0] px;
    pick = $urandom_range(99);
    px = ($urandom_range(3) == 0) ? $urandom : 32'd1000 + $urandom_range(15);
    id = (live_ids.size() > 0 && $urandom_range(3) != 0) ?
         live_ids[$urandom_range(live_ids.size() - 1)] : $urandom;
    if (pick < 40) begin
      if (live_ids.size() < 60) live_ids.push_back(id);
      send_item(KIND_ADD, id, px, $urandom_range(3) == 0 ? $urandom : $urandom_range(50));
    end else if (pick < 55) begin
      send_item(KIND_REMOVE, id, 0, $urandom);
    end else if (pick < 70) begin
      send_item(KIND_UPDATE, id, 0, $urandom_range(4) == 0 ? 0 : $urandom_range(80));
    end else begin
      send_item(KIND_MATCH, $urandom, $urandom_range(1) ? px : $urandom,
                $urandom_range(4) == 0 ? $urandom : $urandom_range(300));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every kind, each corner of the book.
    send_idle_pct = 22;
    take_idle_pct = 72;
    send_item(KIND_MATCH, 32'hFFFF_FFFF, 0, 5);
    send_item(KIND_ADD, 32'd0, 32'd0, 32'd0);
    send_item(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_ADD, 32'd7, 32'd500, 32'd10);
    send_item(KIND_ADD, 32'd8, 32'd500, 32'd20);
    send_item(KIND_ADD, 32'd7, 32'd1, 32'd1);
    send_item(KIND_MATCH, 32'd3, 32'd0, 32'hFFFF_FFFF);
    send_item(KIND_MATCH, 32'd3, 32'd500, 32'd0);
    send_item(KIND_UPDATE, 32'd7, 0, 32'd99);
    send_item(KIND_UPDATE, 32'd0, 0, 32'd0);
    send_item(KIND_UPDATE, 32'd1234, 0, 32'd5);
    send_item(KIND_REMOVE, 32'd4321, 0, 0);
    send_item(KIND_MATCH, 32'd3, 32'd500, 32'd50);
    send_item(KIND_REMOVE, 32'hFFFF_FFFF, 0, 0);
    write_side(1'b0);
    send_item(KIND_MATCH, 32'd9, 32'hFFFF_FFFF, 32'd100);
    // Pile up enough orders to force truncation on both sides.
    for (int i = 0; i < 20; i++) send_item(KIND_ADD, 32'd100 + i, 32'd600 - i, 32'd1);
    send_item(KIND_MATCH, 32'd9, 32'hFFFF_FFFF, 32'd1000);
    write_side(1'b1);
    send_item(KIND_MATCH, 32'd9, 32'd0, 32'd1000);

    // Stall the receiver long while items keep coming, then pause the sender.
    hold_off = 400;
    for (int i = 0; i < 12; i++) random_item();
    pause_sender();

    for (int i = 0; i < 20; i++) random_item();
    write_side(1'b0);
    send_idle_pct = 72;
    take_idle_pct = 22;
    for (int i = 0; i < 20; i++) random_item();
    write_side(1'b1);
    send_idle_pct = 0;
    take_idle_pct = 0;

    // Fill the book to the top, push past it, and walk the full book.
    for (int i = 0; i < MAX_ORDERS; i++) send_item(KIND_ADD, 32'h8000_0000 + i, i, i);
    send_item(KIND_ADD, 32'h7000_0000, 32'd5, 32'd5);
    send_item(KIND_ADD, 32'h8000_0001, 32'd5, 32'd5);
    send_item(KIND_MATCH, 32'd9, 32'd0, 32'hFFFF_FFFF);

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("tb_order_book_side_tracker OK");
    end else begin
      $display("tb_order_book_side_tracker NOT OK");
    end
    $finish;
  end

endmodule
